FILE: rtl/dhc_pkg.sv
// Shared types, constants and the palette for the deviation heatmap colorizer.
package dhc_pkg;

	// Field widths
	localparam int DEV_BITS   = 24;
	localparam int SEV_FRAC   = 16;
	localparam int COLOR_BITS = 8;
	localparam int SEV_W      = SEV_FRAC + 1;

	// Quotient bits produced by the divider, one per stage
	localparam int QUO_BITS  = SEV_FRAC - 1;
	localparam int SEG_SHIFT = SEV_FRAC - 2;

	localparam logic [SEV_W-1:0] SEV_ONE  = SEV_W'(1) << SEV_FRAC;
	localparam logic [SEV_W-1:0] SEV_HALF = SEV_W'(1) << (SEV_FRAC - 1);

	// Palette blend: stop colors are in hundredths
	localparam int PAL_W   = 7;
	localparam int FRAC_W  = SEG_SHIFT + 1;
	localparam int BLEND_W = PAL_W + SEG_SHIFT;
	localparam int SCALE_W = BLEND_W + COLOR_BITS;
	localparam int Y_W     = SCALE_W - SEG_SHIFT;

	// Rounding term: half of 100 * 2^SEG_SHIFT
	localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(50) << SEG_SHIFT;

	// floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for y below 43690
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	localparam int PROD_W = Y_W + RECIP_W;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_TOLERANCE = 1'b0,
		REG_MAXIMUM   = 1'b1
	} reg_idx_t;

	// Control carried alongside the divider
	typedef struct packed {
		logic             bad;
		logic             above;
		logic             fixed;
		logic [SEV_W-1:0] fsev;
		logic             half;
	} tag_t;

	typedef struct packed {
		tag_t                tag;
		logic [DEV_BITS-1:0] rem;
		logic [DEV_BITS-1:0] den;
		logic [QUO_BITS-1:0] quo;
	} div_t;

	// One restoring division step: produce one quotient bit
	function automatic div_t div_step(input div_t x);
		div_t                res;
		logic [DEV_BITS:0]   r2;
		logic [DEV_BITS:0]   diff;
		begin
			res  = x;
			r2   = {x.rem, 1'b0};
			diff = r2 - {1'b0, x.den};
			if (r2 >= {1'b0, x.den}) begin
				res.rem = diff[DEV_BITS-1:0];
				res.quo = {x.quo[QUO_BITS-2:0], 1'b1};
			end else begin
				res.rem = r2[DEV_BITS-1:0];
				res.quo = {x.quo[QUO_BITS-2:0], 1'b0};
			end
			return res;
		end
	endfunction

	// Palette stops at 0, 0.25, 0.5, 0.75, 1; channel 0 red, 1 green, 2 blue
	function automatic logic [PAL_W-1:0] pal_color(input logic [2:0] stop,
			input logic [1:0] ch);
		logic [3*PAL_W-1:0] rgb;
		begin
			unique case (stop)
				3'd0:    rgb = {7'd5,   7'd20, 7'd85};
				3'd1:    rgb = {7'd0,   7'd80, 7'd100};
				3'd2:    rgb = {7'd10,  7'd85, 7'd20};
				3'd3:    rgb = {7'd100, 7'd85, 7'd0};
				3'd4:    rgb = {7'd90,  7'd5,  7'd2};
				default: rgb = '0;
			endcase
			unique case (ch)
				2'd0:    return rgb[3*PAL_W-1:2*PAL_W];
				2'd1:    return rgb[2*PAL_W-1:PAL_W];
				2'd2:    return rgb[PAL_W-1:0];
				default: return '0;
			endcase
		end
	endfunction

endpackage

FILE: rtl/deviation_heatmap_colorizer.sv
// Deviation heatmap colorizer: pipelined severity divider and palette blend.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_ready  | deviation
//  out     | output    | out_valid/out_ready| valid_res severity above_tolerance red green blue
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index cfg_data (0 tolerance, 1 maximum)
//
//  One word enters per cycle while the pipe has room. Stages: a compare stage, a divider
//  setup stage, one stage per quotient bit (15), a rounding stage and three palette
//  stages, of which the last is the output register. The restoring divider sets the
//  depth. Reset clears every stage valid bit and loads tolerance 1024, maximum 4096.
//  A stall at the output holds only the stages behind a full stage; bubbles close up
//  and the input keeps accepting while there is room. cfg_ready is always high.
module deviation_heatmap_colorizer
	import dhc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DEV_BITS-1:0]   deviation,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  valid_res,
	output logic [SEV_W-1:0]      severity,
	output logic                  above_tolerance,
	output logic [COLOR_BITS-1:0] red,
	output logic [COLOR_BITS-1:0] green,
	output logic [COLOR_BITS-1:0] blue,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [DEV_BITS-1:0]   cfg_data
);

	localparam int K = QUO_BITS;

	// Configuration registers
	logic [DEV_BITS-1:0] tol_q;
	logic [DEV_BITS-1:0] max_q;

	// Compare stage
	logic                v_s1;
	logic [DEV_BITS-1:0] dev_s1;
	logic [DEV_BITS-1:0] tol_s1;
	logic [DEV_BITS-1:0] excess_s1;
	logic [DEV_BITS-1:0] span_s1;
	logic                bad_s1, above_s1, eq_s1, dz_s1, tz_s1, mgt_s1;

	// Divider: index 0 is the setup stage, 1..K one quotient bit each
	logic [K:0]   v_div;
	div_t         div_s [K+1];
	logic [K+1:0] en_div;
	div_t         setup;

	// Rounding stage
	logic             v_sr;
	logic             bad_sr, above_sr;
	logic [SEV_W-1:0] sev_sr;
	logic             rbit;
	logic [SEV_W-1:0] qsum;

	// Palette stages
	logic                v_sb, v_sy;
	logic                bad_sb, above_sb, bad_sy, above_sy;
	logic [SEV_W-1:0]    sev_sb, sev_sy;
	logic [BLEND_W-1:0]  blend_sb [3];
	logic [Y_W-1:0]      y_sy [3];
	logic [BLEND_W-1:0]  blend_d [3];
	logic [Y_W-1:0]      y_d [3];
	logic [COLOR_BITS-1:0] z_d [3];

	logic en_out, en_sy, en_sb, en_sr, en_s1;

	// Stage enables: a stage moves when empty or when the next one moves
	assign en_out       = !out_valid || out_ready;
	assign en_sy        = !v_sy || en_out;
	assign en_sb        = !v_sb || en_sy;
	assign en_sr        = !v_sr || en_sb;
	assign en_div[K+1]  = en_sr;
	assign en_s1        = !v_s1 || en_div[0];
	assign in_ready     = en_s1;
	assign cfg_ready    = 1'b1;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= DEV_BITS'(1024);
			max_q <= DEV_BITS'(4096);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOLERANCE: tol_q <= cfg_data;
				REG_MAXIMUM:   max_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Compare deviation against the scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dev_s1    <= deviation;
			tol_s1    <= tol_q;
			excess_s1 <= deviation - tol_q;
			span_s1   <= max_q - tol_q;
			bad_s1    <= max_q < tol_q;
			above_s1  <= deviation > tol_q;
			eq_s1     <= deviation == tol_q;
			dz_s1     <= deviation == '0;
			tz_s1     <= tol_q == '0;
			mgt_s1    <= max_q > tol_q;
		end
	end

	// Pick the fixed severity or the division operands
	always_comb begin
		setup.tag.bad   = bad_s1;
		setup.tag.above = above_s1;
		setup.tag.fixed = 1'b1;
		setup.tag.fsev  = '0;
		setup.tag.half  = 1'b0;
		setup.rem       = dev_s1;
		setup.den       = tol_s1;
		setup.quo       = '0;
		priority if (!tz_s1 && !above_s1) begin
			if (eq_s1) begin
				setup.tag.fsev = SEV_HALF;
			end else begin
				setup.tag.fixed = 1'b0;
			end
		end else if (dz_s1) begin
			setup.tag.fsev = '0;
		end else if (mgt_s1) begin
			if (excess_s1 >= span_s1) begin
				setup.tag.fsev = SEV_ONE;
			end else begin
				setup.tag.fixed = 1'b0;
				setup.tag.half  = 1'b1;
				setup.rem       = excess_s1;
				setup.den       = span_s1;
			end
		end else begin
			setup.tag.fsev = SEV_ONE;
		end
	end

	// Divider stages
	for (genvar k = 0; k <= K; k++) begin : g_div
		assign en_div[k] = !v_div[k] || en_div[k+1];

		if (k == 0) begin : g_setup
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_div[k] <= 1'b0;
				end else if (en_div[k]) begin
					v_div[k] <= v_s1;
				end
			end

			always_ff @(posedge clk) begin
				if (en_div[k] && v_s1) begin
					div_s[k] <= setup;
				end
			end
		end else begin : g_step
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_div[k] <= 1'b0;
				end else if (en_div[k]) begin
					v_div[k] <= v_div[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en_div[k] && v_div[k-1]) begin
					div_s[k] <= div_step(div_s[k-1]);
				end
			end
		end
	end

	// Round the quotient and add the upper-half offset
	always_comb begin
		rbit = {div_s[K].rem, 1'b0} >= {1'b0, div_s[K].den};
		qsum = (div_s[K].tag.half ? SEV_HALF : '0) + SEV_W'(div_s[K].quo) + SEV_W'(rbit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= 1'b0;
		end else if (en_sr) begin
			v_sr <= v_div[K];
		end
	end

	always_ff @(posedge clk) begin
		if (en_sr && v_div[K]) begin
			bad_sr   <= div_s[K].tag.bad;
			above_sr <= div_s[K].tag.above;
			sev_sr   <= div_s[K].tag.fixed ? div_s[K].tag.fsev : qsum;
		end
	end

	// Blend the two surrounding stops in hundredths, scaled by 2^SEG_SHIFT
	always_comb begin
		logic [2:0]              seg;
		logic [FRAC_W-1:0]       f;
		logic [PAL_W-1:0]        p0, p1;
		logic signed [PAL_W:0]   d;
		logic signed [BLEND_W+1:0] acc;
		if (sev_sr[SEV_FRAC]) begin
			seg = 3'd3;
			f   = FRAC_W'(1) << SEG_SHIFT;
		end else begin
			seg = {1'b0, sev_sr[SEV_FRAC-1:SEG_SHIFT]};
			f   = {1'b0, sev_sr[SEG_SHIFT-1:0]};
		end
		for (int c = 0; c < 3; c++) begin
			p0  = pal_color(seg, 2'(c));
			p1  = pal_color(seg + 3'd1, 2'(c));
			d   = $signed({1'b0, p1}) - $signed({1'b0, p0});
			acc = $signed({2'b00, p0, SEG_SHIFT'(0)}) + d * $signed({1'b0, f});
			blend_d[c] = acc[BLEND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sb <= 1'b0;
		end else if (en_sb) begin
			v_sb <= v_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (en_sb && v_sr) begin
			bad_sb   <= bad_sr;
			above_sb <= above_sr;
			sev_sb   <= sev_sr;
			blend_sb <= blend_d;
		end
	end

	// Scale to full color range, add the rounding half, drop the segment bits
	always_comb begin
		logic [SCALE_W-1:0] x;
		for (int c = 0; c < 3; c++) begin
			x      = ({SCALE_W'(blend_sb[c]) << COLOR_BITS}) - SCALE_W'(blend_sb[c])
			         + ROUND_HALF;
			y_d[c] = x[SCALE_W-1:SEG_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sy <= 1'b0;
		end else if (en_sy) begin
			v_sy <= v_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en_sy && v_sb) begin
			bad_sy   <= bad_sb;
			above_sy <= above_sb;
			sev_sy   <= sev_sb;
			y_sy     <= y_d;
		end
	end

	// Divide by 100 through the reciprocal
	always_comb begin
		logic [PROD_W-1:0] prod;
		for (int c = 0; c < 3; c++) begin
			prod   = PROD_W'(y_sy[c]) * PROD_W'(RECIP_100);
			z_d[c] = prod[RECIP_SHIFT +: COLOR_BITS];
		end
	end

	// Output register; an inconsistent scale clears every field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= v_sy;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_sy) begin
			valid_res       <= !bad_sy;
			severity        <= bad_sy ? '0 : sev_sy;
			above_tolerance <= bad_sy ? 1'b0 : above_sy;
			red             <= bad_sy ? '0 : z_d[0];
			green           <= bad_sy ? '0 : z_d[1];
			blue            <= bad_sy ? '0 : z_d[2];
		end
	end

`ifndef ASSERT_OFF
	a_bad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> severity == '0 && !above_tolerance
			&& red == '0 && green == '0 && blue == '0)
		else $error("inconsistent scale word carries nonzero fields");

	a_sev_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> severity <= SEV_ONE)
		else $error("severity above one");

	a_above_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res && above_tolerance |-> severity >= SEV_HALF)
		else $error("above-tolerance word below half severity");

	a_below_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res && !above_tolerance |-> severity <= SEV_HALF)
		else $error("within-tolerance word above half severity");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && v_sy |=> out_valid && v_sy)
		else $error("stalled word dropped from the last stages");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the deviation heatmap colorizer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dhc_pkg::*;

	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 55;

	localparam logic [DEV_BITS-1:0] DEV_TOP = '1;

	// Stop colors in hundredths: red, green, blue
	localparam int unsigned STOP_RGB [5][3] = '{
		'{5, 20, 85}, '{0, 80, 100}, '{10, 85, 20}, '{100, 85, 0}, '{90, 5, 2}
	};

	typedef struct packed {
		logic                  ok;
		logic [SEV_W-1:0]      sev;
		logic                  above;
		logic [COLOR_BITS-1:0] r;
		logic [COLOR_BITS-1:0] g;
		logic [COLOR_BITS-1:0] b;
	} heat_t;

	typedef enum logic {ROW_DEV, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		reg_idx_t            idx;
		logic [DEV_BITS-1:0] value;
		logic                typed;
		heat_t               want;
	} step_t;

	// Results that can be read off the palette directly
	localparam heat_t H_NONE    = '0;
	localparam heat_t H_BAD     = '0;
	localparam heat_t H_ZERO    = '{1'b1, 17'd0, 1'b0, 8'd13, 8'd51, 8'd217};
	localparam heat_t H_QUARTER = '{1'b1, 17'd16384, 1'b0, 8'd0, 8'd204, 8'd255};
	localparam heat_t H_HALF    = '{1'b1, 17'd32768, 1'b0, 8'd26, 8'd217, 8'd51};
	localparam heat_t H_3Q      = '{1'b1, 17'd49152, 1'b1, 8'd255, 8'd217, 8'd0};
	localparam heat_t H_FULL    = '{1'b1, 17'd65536, 1'b1, 8'd230, 8'd13, 8'd5};

	localparam int PLAN_ROWS = 31;
	localparam step_t PLAN [PLAN_ROWS] = '{
		'{ROW_DEV, REG_TOLERANCE, 24'd0,        1'b1, H_ZERO},
		'{ROW_DEV, REG_TOLERANCE, 24'd512,      1'b1, H_QUARTER},
		'{ROW_DEV, REG_TOLERANCE, 24'd1023,     1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd1024,     1'b1, H_HALF},
		'{ROW_DEV, REG_TOLERANCE, 24'd1025,     1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd2560,     1'b1, H_3Q},
		'{ROW_DEV, REG_TOLERANCE, 24'd4096,     1'b1, H_FULL},
		'{ROW_DEV, REG_TOLERANCE, 24'd16777215, 1'b1, H_FULL},
		// zero tolerance with zero span
		'{ROW_CFG, REG_TOLERANCE, 24'd0,        1'b0, H_NONE},
		'{ROW_CFG, REG_MAXIMUM,   24'd0,        1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd0,        1'b1, H_ZERO},
		'{ROW_DEV, REG_TOLERANCE, 24'd1,        1'b1, H_FULL},
		'{ROW_DEV, REG_TOLERANCE, 24'd16777215, 1'b1, H_FULL},
		// maximum below tolerance
		'{ROW_CFG, REG_TOLERANCE, 24'd5000,     1'b0, H_NONE},
		'{ROW_CFG, REG_MAXIMUM,   24'd4999,     1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd123,      1'b1, H_BAD},
		'{ROW_DEV, REG_TOLERANCE, 24'd16777215, 1'b1, H_BAD},
		// both registers at full scale
		'{ROW_CFG, REG_TOLERANCE, 24'd16777215, 1'b0, H_NONE},
		'{ROW_CFG, REG_MAXIMUM,   24'd16777215, 1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd16777215, 1'b1, H_HALF},
		'{ROW_DEV, REG_TOLERANCE, 24'd16777214, 1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd0,        1'b1, H_ZERO},
		// zero tolerance, widest span
		'{ROW_CFG, REG_TOLERANCE, 24'd0,        1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd1,        1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd8388608,  1'b0, H_NONE},
		// narrowest proper span
		'{ROW_CFG, REG_TOLERANCE, 24'd1,        1'b0, H_NONE},
		'{ROW_CFG, REG_MAXIMUM,   24'd3,        1'b0, H_NONE},
		'{ROW_DEV, REG_TOLERANCE, 24'd2,        1'b1, H_3Q},
		'{ROW_DEV, REG_TOLERANCE, 24'd1,        1'b1, H_HALF},
		'{ROW_CFG, REG_TOLERANCE, 24'd1024,     1'b0, H_NONE},
		'{ROW_CFG, REG_MAXIMUM,   24'd4096,     1'b0, H_NONE}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [DEV_BITS-1:0]   deviation;
	logic                  out_valid;
	logic                  out_ready;
	logic                  valid_res;
	logic [SEV_W-1:0]      severity;
	logic                  above_tolerance;
	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [0:0]            cfg_index;
	logic [DEV_BITS-1:0]   cfg_data;

	// Register copies seen by the color predictor
	logic [DEV_BITS-1:0] tol_reg;
	logic [DEV_BITS-1:0] max_reg;

	heat_t pending_colors [$];
	int    mismatches;
	int    quiet_cycles;
	logic  calm;
	logic  hold_req;

	deviation_heatmap_colorizer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.deviation       (deviation),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.valid_res       (valid_res),
		.severity        (severity),
		.above_tolerance (above_tolerance),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// num * 2^k / den, rounded half up; num below den
	function automatic bit [63:0] rounded_quotient(bit [63:0] num, bit [63:0] den, int k);
		bit [63:0] q;
		bit [63:0] r;
		q = 0;
		r = num;
		for (int i = 0; i < k; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		if (r >= den - r)
			q = q + 1;
		return q;
	endfunction

	// Map a deviation onto severity: lower half up to tolerance, upper half beyond
	function automatic bit [63:0] severity_for(bit [63:0] dev);
		bit [63:0] tol;
		bit [63:0] mx;
		bit [63:0] one;
		tol = tol_reg;
		mx  = max_reg;
		one = 64'd1 << SEV_FRAC;
		if (dev <= tol && tol > 0) begin
			if (dev == tol)
				return one >> 1;
			return rounded_quotient(dev, tol, SEV_FRAC - 1);
		end
		if (dev == 0)
			return 0;
		if (mx > tol) begin
			if (dev - tol >= mx - tol)
				return one;
			return (one >> 1) + rounded_quotient(dev - tol, mx - tol, SEV_FRAC - 1);
		end
		return one;
	endfunction

	// Blend the two stops around sev for one channel, rounded half up
	function automatic bit [COLOR_BITS-1:0] blend_channel(bit [63:0] sev, int ch);
		bit [63:0] seg;
		bit [63:0] f;
		bit [63:0] seg_len;
		bit [63:0] num;
		bit [63:0] den;
		seg_len = 64'd1 << SEG_SHIFT;
		seg = sev >> SEG_SHIFT;
		if (seg > 3)
			seg = 3;
		f   = sev - (seg << SEG_SHIFT);
		num = (STOP_RGB[seg][ch] * (seg_len - f) + STOP_RGB[seg + 1][ch] * f)
			* ((64'd1 << COLOR_BITS) - 1);
		den = 100 * seg_len;
		return COLOR_BITS'((2 * num + den) / (2 * den));
	endfunction

	function automatic heat_t colorize(logic [DEV_BITS-1:0] dev);
		heat_t     res;
		bit [63:0] sev;
		res = '0;
		if (max_reg < tol_reg)
			return res;
		sev = severity_for(dev);
		if (sev > (64'd1 << SEV_FRAC))
			sev = 64'd1 << SEV_FRAC;
		res.ok    = 1'b1;
		res.sev   = SEV_W'(sev);
		res.above = dev > tol_reg;
		res.r     = blend_channel(sev, 0);
		res.g     = blend_channel(sev, 1);
		res.b     = blend_channel(sev, 2);
		return res;
	endfunction

	// Offer one word, with random gaps ahead of it, and log what it should give
	task automatic send_dev(logic [DEV_BITS-1:0] d, logic typed, heat_t want);
		while (!calm && $urandom_range(0, 99) < 16) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		deviation <= d;
		do @(posedge clk); while (!in_ready);
		pending_colors.push_back(typed ? want : colorize(d));
	endtask

	// Write one register once the pipe has drained
	task automatic write_reg(reg_idx_t idx, logic [DEV_BITS-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TOLERANCE)
			tol_reg = value;
		else
			max_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Aim at the interesting spots of the current scale most of the time
	function automatic logic [DEV_BITS-1:0] pick_deviation();
		bit [63:0] hi;
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return tol_reg;
			2:       return tol_reg + 1'b1;
			3:       return tol_reg - 1'b1;
			4:       return max_reg;
			5:       return max_reg + 1'b1;
			6:       return max_reg - 1'b1;
			7, 8, 9: return DEV_BITS'($urandom);
			default: begin
				hi = max_reg + (max_reg >> 2) + 1;
				if (hi > DEV_TOP)
					hi = DEV_TOP;
				return DEV_BITS'($urandom_range(0, int'(hi)));
			end
		endcase
	endfunction

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: random stalls, a calm stretch, and one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	// Check each result word against the oldest prediction
	always @(posedge clk) begin
		heat_t got;
		heat_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{valid_res, severity, above_tolerance, red, green, blue};
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected result word, got %p", $time, got);
				mismatches++;
			end else begin
				want = pending_colors.pop_front();
				report_field("valid_res", want.ok, got.ok);
				report_field("severity", want.sev, got.sev);
				report_field("above_tolerance", want.above, got.above);
				report_field("red", want.r, got.r);
				report_field("green", want.g, got.g);
				report_field("blue", want.b, got.b);
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("deviation_heatmap_colorizer regression: fail");
			$finish;
		end
	end

	initial begin
		logic [DEV_BITS-1:0] t;
		logic [DEV_BITS-1:0] m;
		in_valid     = 1'b0;
		deviation    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_TOLERANCE;
		cfg_data     = '0;
		arst_n       = 1'b0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		tol_reg      = 24'd1024;
		max_reg      = 24'd4096;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_CFG)
				write_reg(PLAN[i].idx, PLAN[i].value);
			else
				send_dev(PLAN[i].value, PLAN[i].typed, PLAN[i].want);
		end

		// Random phases, each under its own scale
		for (int p = 0; p < PHASES; p++) begin
			case (p % 5)
				0: begin
					t = DEV_BITS'($urandom_range(1, 4000));
					m = t + DEV_BITS'($urandom_range(0, 20000));
				end
				1: begin
					t = DEV_BITS'($urandom);
					m = DEV_BITS'($urandom);
				end
				2: begin
					t = '0;
					m = DEV_BITS'($urandom_range(0, 70000));
				end
				3: begin
					t = DEV_BITS'($urandom_range(1, int'(DEV_TOP)));
					m = t;
				end
				default: begin
					t = DEV_BITS'($urandom_range(0, int'(DEV_TOP) - 1));
					m = DEV_TOP;
				end
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(REG_TOLERANCE, t);
				write_reg(REG_MAXIMUM, m);
			end else begin
				write_reg(REG_MAXIMUM, m);
				write_reg(REG_TOLERANCE, t);
			end
			calm = (p == 3);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Stall the receiver long enough to back the pipe up to the input
				if (p == 5 && k == 5)
					hold_req = 1'b1;
				send_dev(pick_deviation(), 1'b0, H_NONE);
			end
			calm = 1'b0;
		end

		// Drain, then keep watching for stray words before the verdict
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0) begin
			$display("deviation_heatmap_colorizer regression: pass");
		end else begin
			$display("deviation_heatmap_colorizer regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/dhc_pkg.sv
rtl/deviation_heatmap_colorizer.sv
tb/sv/tb.sv
